@@ rtl/core/clksyn_pkg.sv @@
// Shared types and constants for the serial clock synthesiser programmer.
package clksyn_pkg;

  localparam int unsigned FreqW      = 28;
  localparam int unsigned WordW      = 20;
  localparam int unsigned CountW     = 5;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned NW         = 10;

  localparam logic [CountW-1:0] FrameBits = CountW'(20);
  localparam logic [NW-1:0]     NOffset   = NW'(257);

  // 143181818 / 460 = 311264 remainder 378; the remainder part N*378/460 = N*189/230
  // is taken by a reciprocal multiply: floor(N * 189 * ceil(2^24/230) / 2^24).
  localparam int unsigned QuotW      = 19;
  localparam logic [QuotW-1:0] FreqQuot = QuotW'(311264);
  localparam int unsigned RecipW     = 24;
  localparam logic [RecipW-1:0] FreqRecip = RecipW'(13786605);
  localparam int unsigned RecipShift = 24;

  typedef logic [FreqW-1:0] freq_t;
  typedef logic [WordW-1:0] word_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef struct packed {
    idx_t  idx;
    freq_t freq;
  } dec_t;

  typedef struct packed {
    logic  en;
    idx_t  idx;
    freq_t data;
  } tbl_wr_t;

endpackage

@@ rtl/core/clksyn_decode.sv @@
// Frame decoder: frequency of the word that the next serial beat completes.
module clksyn_decode (
  input  clksyn_pkg::word_t shift_word,
  output clksyn_pkg::dec_t  dec
);
  import clksyn_pkg::*;

  logic [NW-1:0]            n_val;
  logic [NW+QuotW-1:0]      hi_prod;
  logic [NW+RecipW-1:0]     lo_prod;
  logic [NW-1:0]            lo_part;
  freq_t                    base;
  logic [1:0]               div_code;

  // After the final shift the word moves right by one, so read its fields one bit higher.
  always_comb begin
    n_val    = NW'(shift_word[15:8]) + NOffset;
    hi_prod  = (NW+QuotW)'(n_val) * (NW+QuotW)'(FreqQuot);
    lo_prod  = (NW+RecipW)'(n_val) * (NW+RecipW)'(FreqRecip);
    lo_part  = lo_prod[RecipShift +: NW];
    base     = FreqW'(hi_prod) + FreqW'(lo_part);
    div_code = shift_word[18:17];
    dec.idx  = shift_word[6:3];
    // divide by 8, 4, 2, 1 for codes 0..3
    dec.freq = base >> (~div_code);
  end

endmodule

@@ rtl/core/clksyn_serial.sv @@
// Serial frame receiver: clock edge detect, frame shifter and table write request.
module clksyn_serial (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               strobe_req,
  input  logic [3:0]         pins,
  input  clksyn_pkg::dec_t   dec,
  output clksyn_pkg::word_t  shift_word,
  output clksyn_pkg::tbl_wr_t wr
);
  import clksyn_pkg::*;

  logic              in_frame;
  logic              in_frame_next;
  logic [CountW-1:0] bit_count;
  logic [CountW-1:0] bit_count_next;
  word_t             shift_word_next;
  logic              prev_clock_pin;
  logic              edge_seen;
  logic [CountW-1:0] count_inc;

  always_comb begin
    edge_seen       = accept && strobe_req && pins[3] && !prev_clock_pin;
    count_inc       = bit_count + CountW'(1);
    in_frame_next   = in_frame;
    bit_count_next  = bit_count;
    shift_word_next = shift_word;
    wr.en           = 1'b0;
    wr.idx          = dec.idx;
    wr.data         = dec.freq;
    if (edge_seen) begin
      if (!in_frame) begin
        in_frame_next  = pins[2];
        bit_count_next = '0;
      end else begin
        shift_word_next = {pins[2], shift_word[WordW-1:1]};
        bit_count_next  = count_inc;
        if (count_inc == FrameBits) begin
          wr.en         = 1'b1;
          in_frame_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      bit_count      <= '0;
      shift_word     <= '0;
      prev_clock_pin <= 1'b0;
    end else begin
      in_frame   <= in_frame_next;
      bit_count  <= bit_count_next;
      shift_word <= shift_word_next;
      // record the clock level only on strobed beats
      if (accept && strobe_req) begin
        prev_clock_pin <= pins[3];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bit_count <= FrameBits)
    else $error("bit count ran past frame length");

  a_frame_count: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> bit_count < FrameBits)
    else $error("frame open with full bit count");

  a_write_ends: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> !in_frame && bit_count == FrameBits)
    else $error("frame still open after table write");

endmodule

@@ rtl/core/clksyn_table.sv @@
// Sixteen-entry frequency table with write-through read of the selected entry.
module clksyn_table (
  input  logic                clk,
  input  logic                rst,
  input  clksyn_pkg::tbl_wr_t wr,
  input  clksyn_pkg::idx_t    rd_idx,
  output clksyn_pkg::freq_t   rd_data
);
  import clksyn_pkg::*;

  freq_t freq_table [TableDepth];

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_table <= '{default: '0};
    end else if (wr.en) begin
      freq_table[wr.idx] <= wr.data;
    end
  end

  // the result shows the table after this beat's write
  always_comb begin
    if (wr.en && wr.idx == rd_idx) begin
      rd_data = wr.data;
    end else begin
      rd_data = freq_table[rd_idx];
    end
  end

endmodule

@@ rtl/core/serial_clock_synth_programmer.sv @@
// Top level: serial clock synthesiser programmer with registered result.
// Latency: the result for a beat is valid in the cycle after it is accepted.
// Throughput: one beat per cycle; input is taken while the result register is empty or drains.
// The path from the result register ready back to in_ready is the only cross-side link.
// Reset (synchronous): frame idle, shifter and clock level cleared, all table entries zero,
// result register empty.
module serial_clock_synth_programmer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              strobe_req,
  input  logic [3:0]        pins,
  output logic              out_valid,
  input  logic              out_ready,
  output clksyn_pkg::freq_t clock_hz
);
  import clksyn_pkg::*;

  logic    accept;
  word_t   shift_word;
  dec_t    dec;
  tbl_wr_t wr;
  freq_t   rd_data;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  clksyn_decode u_decode (
    .shift_word (shift_word),
    .dec        (dec)
  );

  clksyn_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .strobe_req (strobe_req),
    .pins       (pins),
    .dec        (dec),
    .shift_word (shift_word),
    .wr         (wr)
  );

  clksyn_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_idx  (pins),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      clock_hz <= rd_data;
    end
  end

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && clock_hz == $past(rd_data))
    else $error("accepted beat left no result");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |-> !wr.en)
    else $error("table written without an accepted beat");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the serial clock synthesiser programmer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import clksyn_pkg::*;

  localparam longint unsigned FreqNum    = 64'd143181818;
  localparam longint unsigned FreqDen    = 64'd460;
  localparam longint unsigned NBase      = 64'd257;
  localparam int              WordBits   = 20;
  localparam int              RandBeats  = 400;
  localparam int              MaxWait    = 13;
  localparam int              CycleLimit = 200000;
  localparam int              DirRows    = 17;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       strobe_req;
  logic [3:0] pins;
  logic       out_valid;
  logic       out_ready;
  freq_t      clock_hz;

  serial_clock_synth_programmer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .strobe_req (strobe_req),
    .pins       (pins),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .clock_hz   (clock_hz)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Synthesiser state as the bench sees it
  logic       frm_active;
  logic [4:0] frm_count;
  word_t      frm_word;
  logic       last_sclk;
  freq_t      freq_tab [TableDepth];

  freq_t      pending_hz [$];
  freq_t      want_hz;
  int         mismatches;
  int         beats_sent;
  int         cycle_count;
  bit         send_idle_on;
  bit         recv_idle_on;

  typedef struct {
    logic       strobe;
    logic [3:0] pin_val;
    freq_t      hz;
  } dir_row_t;

  // Nothing is programmed yet, so every read in this table returns zero
  dir_row_t dir_rows [DirRows] = '{
    '{1'b0, 4'h0, 28'd0},   // strobe clear, lowest pins
    '{1'b0, 4'hf, 28'd0},   // strobe clear with clock high: level not recorded
    '{1'b1, 4'h7, 28'd0},
    '{1'b1, 4'h8, 28'd0},   // edge in idle with data low: stay idle
    '{1'b1, 4'hb, 28'd0},   // clock held high, no edge
    '{1'b1, 4'h0, 28'd0},
    '{1'b0, 4'hc, 28'd0},   // edge without strobe is ignored
    '{1'b1, 4'h3, 28'd0},
    '{1'b1, 4'hc, 28'd0},   // edge with data high opens a frame
    '{1'b0, 4'h5, 28'd0},
    '{1'b1, 4'h5, 28'd0},
    '{1'b1, 4'he, 28'd0},
    '{1'b1, 4'h1, 28'd0},
    '{1'b1, 4'h9, 28'd0},
    '{1'b1, 4'hf, 28'd0},
    '{1'b1, 4'h2, 28'd0},
    '{1'b1, 4'hd, 28'd0}
  };

  task automatic report_mismatch(input string what, input freq_t got, input freq_t want);
    $display("MISMATCH %s: clock_hz got %0d expected %0d (cycle %0d)",
             what, got, want, cycle_count);
    mismatches++;
  endtask

  task automatic synth_reset();
    frm_active = 1'b0;
    frm_count  = '0;
    frm_word   = '0;
    last_sclk  = 1'b0;
    for (int i = 0; i < TableDepth; i++) freq_tab[i] = '0;
  endtask

  // Advance the synthesiser by one pin sample and return the selected entry
  task automatic synth_step(input logic stb, input logic [3:0] p, output freq_t hz);
    longint unsigned n_val;
    longint unsigned d_val;
    longint unsigned f_val;
    if (stb) begin
      if (p[3] && !last_sclk) begin
        if (!frm_active) begin
          frm_active = p[2];
          frm_count  = '0;
        end else begin
          frm_word  = {p[2], frm_word[WordBits-1:1]};
          frm_count = frm_count + 5'd1;
          if (frm_count == 5'd20) begin
            n_val = 64'(frm_word[14:7]) + NBase;
            d_val = 64'd8 >> frm_word[17:16];
            f_val = (FreqNum * n_val) / (FreqDen * d_val);
            freq_tab[frm_word[5:2]] = f_val[FreqW-1:0];
            frm_active = 1'b0;
          end
        end
      end
      last_sclk = p[3];
    end
    hz = freq_tab[p];
  endtask

  // Present one beat, hold it until taken, then log what should come back
  task automatic send_beat(input logic stb, input logic [3:0] p, input bit typed,
                           input freq_t typed_hz);
    int    gap;
    freq_t hz;
    gap = send_idle_on ? $urandom_range(0, MaxWait) : 0;
    if ($urandom_range(0, 29) == 0) send_idle_on = !send_idle_on;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    strobe_req <= stb;
    pins       <= p;
    do @(posedge clk); while (!in_ready);
    synth_step(stb, p, hz);
    pending_hz.push_back(typed ? typed_hz : hz);
    beats_sent++;
  endtask

  // One serial clock edge carrying the given data bit, with the odd stray beat
  task automatic clock_bit(input logic d);
    int r;
    send_beat(1'b1, {1'b0, 3'($urandom)}, 1'b0, '0);
    r = $urandom_range(0, 7);
    if (r == 0) send_beat(1'b0, 4'($urandom), 1'b0, '0);
    else if (r == 1) send_beat(1'b1, {1'b0, 3'($urandom)}, 1'b0, '0);
    send_beat(1'b1, {1'b1, d, 2'($urandom)}, 1'b0, '0);
  endtask

  task automatic send_frame(input word_t w);
    // finish any frame left open by stray beats first
    while (frm_active) clock_bit(1'($urandom));
    clock_bit(1'b1);
    for (int i = 0; i < WordBits; i++) clock_bit(w[i]);
  endtask

  task automatic drain_results();
    while (pending_hz.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("serial_clock_synth_programmer regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_hz.size() == 0) begin
        report_mismatch("unexpected beat", clock_hz, '0);
      end else begin
        want_hz = pending_hz.pop_front();
        if (clock_hz !== want_hz) report_mismatch("clock_hz", clock_hz, want_hz);
      end
    end
  end

  // Result side: random stalls, with stretches of none
  initial begin
    int stall;
    out_ready    = 1'b0;
    recv_idle_on = 1'b1;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = recv_idle_on ? $urandom_range(0, MaxWait) : 0;
      if ($urandom_range(0, 29) == 0) recv_idle_on = !recv_idle_on;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int pick;
    cycle_count  = 0;
    mismatches   = 0;
    beats_sent   = 0;
    send_idle_on = 1'b1;
    rst          = 1'b1;
    in_valid     = 1'b0;
    strobe_req   = 1'b0;
    pins         = 4'h0;
    synth_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i].strobe, dir_rows[i].pin_val, 1'b1, dir_rows[i].hz);

    // hold off until every result so far is back
    in_valid <= 1'b0;
    drain_results();
    @(posedge clk);

    // top and bottom of the frequency range; last bit high so entry 15 can read back at once
    send_frame({1'b1, 1'b0, 2'b11, 1'b0, 8'hff, 1'b0, 4'hf, 2'b11});
    send_frame({1'b0, 1'b1, 2'b00, 1'b1, 8'h00, 1'b1, 4'h0, 2'b00});

    while (beats_sent < RandBeats) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_frame(20'($urandom));
      end else begin
        repeat ($urandom_range(1, 12)) send_beat(1'($urandom), 4'($urandom), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("serial_clock_synth_programmer regression: pass");
    end else begin
      $display("serial_clock_synth_programmer regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/clksyn_pkg.sv
rtl/core/clksyn_decode.sv
rtl/core/clksyn_serial.sv
rtl/core/clksyn_table.sv
rtl/core/serial_clock_synth_programmer.sv
bench/tb_top.sv
